>>> rtl/ir_packet_receiver_defines.svh
// Assertion macros shared by the IR packet receiver RTL.
// Included by files that check their own logic; depends on nothing.
`ifndef IR_PACKET_RECEIVER_DEFINES_SVH
`define IR_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IRPR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ir_packet_receiver: check failed");

// Next-cycle implication, disabled while reset is high.
`define IRPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ir_packet_receiver: check failed");

`endif

>>> rtl/ir_pr_pkg.sv
// Shared types and constants of the IR packet receiver.
// Used by every module of the block; depends on nothing.
package ir_pr_pkg;

   // Configuration port widths and register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_DELAY  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_CODE_A  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_CODE_B  = 3'd4;

   // Register values after reset.
   localparam logic [15:0] RST_START_DELAY  = 16'd844;
   localparam logic [15:0] RST_BIT_PERIOD   = 16'd416;
   localparam logic [15:0] RST_BYTE_TIMEOUT = 16'd5000;
   localparam logic [7:0]  RST_LONG_CODE_A  = 8'h50;
   localparam logic [7:0]  RST_LONG_CODE_B  = 8'h61;

   // Result status codes.
   localparam logic [1:0] STATUS_VALID    = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

   // Packet length codes.
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_SHORT = 3'd2;
   localparam logic [2:0] LEN_LONG  = 3'd4;

   // Byte sum of a good packet.
   localparam logic [7:0] CHECKSUM_GOOD = 8'hFF;

   typedef struct packed {
      logic [15:0] start_delay;
      logic [15:0] bit_period;
      logic [15:0] byte_timeout;
      logic [7:0]  long_code_a;
      logic [7:0]  long_code_b;
   } cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] packet_length;
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [7:0] byte_fourth;
   } result_type;

endpackage

>>> rtl/ir_packet_receiver.sv
// Top level of the IR packet receiver: sample register, decoder, result register.
// Depends on ir_pr_pkg, ir_pr_csr, ir_pr_decoder, ir_pr_rsp_reg and the defines header.
//
// Usage:
//   req_*  : one item per tick, carrying one sample of the demodulated IR line.
//   rsp_*  : one item per finished packet (valid or checksum failure) or per
//            timeout inside a packet; most samples give no result.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Path: an accepted item waits in the sample register until the result slot has
//   room; the decoder then steps on it and any result is loaded into the result register.
// Throughput: one item per cycle while results are taken on rsp_ready; the decoder
//   state, held between the sample register and the result register, updates once per item.
// Reset: synchronous; returns to idle waiting for a high line and reloads the
//   register defaults (start delay 844, bit period 416, timeout 5000, long
//   codes 0x50 and 0x61).
// Stall: while a result waits on rsp_ready, one more item is taken into the
//   sample register; further items are held off by req_ready until the result
//   is taken, and no sample is lost.
`include "ir_packet_receiver_defines.svh"

module ir_packet_receiver
   import ir_pr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_line_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [2:0]             rsp_packet_length,
   output logic [7:0]             rsp_byte_first,
   output logic [7:0]             rsp_byte_second,
   output logic [7:0]             rsp_byte_third,
   output logic [7:0]             rsp_byte_fourth,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic       line_ff;
   logic       advance;
   logic       out_space;
   logic       dec_valid;
   result_type dec_result;
   result_type rsp_result;

   assign csr_ready = 1'b1;

   ir_pr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Sample register: the held item moves on when the result slot has room.
   assign advance     = in_valid_ff && out_space;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         line_ff <= req_line_level;
      end
   end

   ir_pr_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .line_level (line_ff),
      .cfg        (cfg),
      .res_valid  (dec_valid),
      .res        (dec_result)
   );

   ir_pr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (dec_valid),
      .load_data (dec_result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_result),
      .space     (out_space)
   );

   assign rsp_status        = rsp_result.status;
   assign rsp_packet_length = rsp_result.packet_length;
   assign rsp_byte_first    = rsp_result.byte_first;
   assign rsp_byte_second   = rsp_result.byte_second;
   assign rsp_byte_third    = rsp_result.byte_third;
   assign rsp_byte_fourth   = rsp_result.byte_fourth;

   // A timeout result carries no length and no bytes.
   `IRPR_ASSERT_SAME(a_timeout_empty, clock, reset,
      rsp_valid && rsp_status == STATUS_TIMEOUT,
      rsp_packet_length == LEN_NONE && rsp_byte_first == 8'd0 &&
      rsp_byte_second == 8'd0 && rsp_byte_third == 8'd0 && rsp_byte_fourth == 8'd0)
   // A short packet leaves the upper two bytes zero.
   `IRPR_ASSERT_SAME(a_short_upper_zero, clock, reset,
      rsp_valid && rsp_packet_length == LEN_SHORT,
      rsp_byte_third == 8'd0 && rsp_byte_fourth == 8'd0)
   // A held sample stays until the decoder takes it.
   `IRPR_ASSERT_NEXT(a_sample_held, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(line_ff))

endmodule

>>> rtl/ir_pr_csr.sv
// Configuration registers of the IR packet receiver.
// Depends on ir_pr_pkg for the register indexes, reset values and cfg_type.
module ir_pr_csr
   import ir_pr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write; indexes past the list leave everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_DELAY:  cfg_in.start_delay  = csr_data;
            CSR_BIT_PERIOD:   cfg_in.bit_period   = csr_data;
            CSR_BYTE_TIMEOUT: cfg_in.byte_timeout = csr_data;
            CSR_LONG_CODE_A:  cfg_in.long_code_a  = csr_data[7:0];
            CSR_LONG_CODE_B:  cfg_in.long_code_b  = csr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay  <= RST_START_DELAY;
         cfg_ff.bit_period   <= RST_BIT_PERIOD;
         cfg_ff.byte_timeout <= RST_BYTE_TIMEOUT;
         cfg_ff.long_code_a  <= RST_LONG_CODE_A;
         cfg_ff.long_code_b  <= RST_LONG_CODE_B;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/ir_pr_decoder.sv
// Frame decoder: advances the receiver state by one line sample per step.
// Depends on ir_pr_pkg and on the assertion macros in the defines header.
`include "ir_packet_receiver_defines.svh"

module ir_pr_decoder
   import ir_pr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       line_level,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE_HIGH = 3'd0,
      PH_IDLE_LOW  = 3'd1,
      PH_START     = 3'd2,
      PH_BIT       = 3'd3,
      PH_GAP_HIGH  = 3'd4,
      PH_GAP_LOW   = 3'd5
   } phase_type;

   phase_type   phase_ff,    phase_in;
   logic [15:0] tick_ff,     tick_in;
   logic [7:0]  shift_ff,    shift_in;
   logic [3:0]  bit_ff,      bit_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [7:0]  sum_ff,      sum_in;
   logic        long_ff,     long_in;
   logic [7:0]  held_ff [3];

   logic        held_we;
   logic [15:0] tick_inc;
   logic [15:0] limit;
   logic [7:0]  shift_new;
   logic [3:0]  bit_new;
   logic [7:0]  sum_new;
   logic        long_new;
   logic        last_byte;

   // Values a sampled data bit would produce.
   assign tick_inc  = tick_ff + 16'd1;
   assign limit     = (phase_ff == PH_START) ? cfg.start_delay : cfg.bit_period;
   assign shift_new = {line_level, shift_ff[7:1]};
   assign bit_new   = bit_ff + 4'd1;
   assign sum_new   = (byte_idx_ff == 2'd0) ? shift_new : sum_ff + shift_new;
   assign long_new  = (byte_idx_ff == 2'd0)
                      ? (shift_new == cfg.long_code_a || shift_new == cfg.long_code_b)
                      : long_ff;
   assign last_byte = long_new ? (byte_idx_ff == 2'd3) : (byte_idx_ff != 2'd0);

   // Next state and the result of this step.
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      shift_in    = shift_ff;
      bit_in      = bit_ff;
      byte_idx_in = byte_idx_ff;
      sum_in      = sum_ff;
      long_in     = long_ff;
      held_we     = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      if (step_en) begin
         case (phase_ff)
            PH_IDLE_LOW: begin
               if (!line_level) begin
                  byte_idx_in = 2'd0;
                  sum_in      = 8'd0;
                  long_in     = 1'b0;
                  tick_in     = 16'd0;
                  shift_in    = 8'd0;
                  bit_in      = 4'd0;
                  phase_in    = PH_START;
               end
            end
            PH_START, PH_BIT: begin
               tick_in = tick_inc;
               if (tick_inc >= limit) begin
                  tick_in  = 16'd0;
                  shift_in = shift_new;
                  bit_in   = bit_new;
                  phase_in = PH_BIT;
                  if (bit_new >= 4'd8) begin
                     sum_in  = sum_new;
                     long_in = long_new;
                     if (last_byte) begin
                        // Packet complete: report it and return to idle.
                        res_valid         = 1'b1;
                        res.status        = (sum_new == CHECKSUM_GOOD)
                                            ? STATUS_VALID : STATUS_CHECKSUM;
                        res.packet_length = long_new ? LEN_LONG : LEN_SHORT;
                        res.byte_first    = held_ff[0];
                        res.byte_second   = long_new ? held_ff[1] : shift_new;
                        res.byte_third    = long_new ? held_ff[2] : 8'd0;
                        res.byte_fourth   = long_new ? shift_new : 8'd0;
                        phase_in          = PH_IDLE_HIGH;
                     end else begin
                        held_we     = 1'b1;
                        byte_idx_in = byte_idx_ff + 2'd1;
                        phase_in    = PH_GAP_HIGH;
                     end
                  end
               end
            end
            PH_GAP_HIGH, PH_GAP_LOW: begin
               if (phase_ff == PH_GAP_HIGH && line_level) begin
                  tick_in  = 16'd0;
                  phase_in = PH_GAP_LOW;
               end else if (phase_ff == PH_GAP_LOW && !line_level) begin
                  tick_in  = 16'd0;
                  shift_in = 8'd0;
                  bit_in   = 4'd0;
                  phase_in = PH_START;
               end else begin
                  tick_in = tick_inc;
                  if (tick_inc >= cfg.byte_timeout) begin
                     // Awaited level never came: report a timeout.
                     res_valid         = 1'b1;
                     res.status        = STATUS_TIMEOUT;
                     res.packet_length = LEN_NONE;
                     phase_in          = PH_IDLE_HIGH;
                  end
               end
            end
            default: begin
               phase_in = line_level ? PH_IDLE_LOW : PH_IDLE_HIGH;
            end
         endcase
      end
   end

   // Receiver state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE_HIGH;
         tick_ff     <= 16'd0;
         shift_ff    <= 8'd0;
         bit_ff      <= 4'd0;
         byte_idx_ff <= 2'd0;
         sum_ff      <= 8'd0;
         long_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         shift_ff    <= shift_in;
         bit_ff      <= bit_in;
         byte_idx_ff <= byte_idx_in;
         sum_ff      <= sum_in;
         long_ff     <= long_in;
      end
   end

   // Bytes held until the packet completes; only written entries are read.
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[byte_idx_ff] <= shift_new;
      end
   end

   // A result only comes from the last data bit or from a gap wait.
   `IRPR_ASSERT_SAME(a_result_phase, clock, reset, res_valid,
      phase_ff == PH_BIT || phase_ff == PH_GAP_HIGH || phase_ff == PH_GAP_LOW)
   // A short packet waits in a gap only after its first byte.
   `IRPR_ASSERT_SAME(a_short_gap_index, clock, reset,
      (phase_ff == PH_GAP_HIGH || phase_ff == PH_GAP_LOW) && !long_ff,
      byte_idx_ff == 2'd1)
   // The bit counter never passes one full byte.
   `IRPR_ASSERT_SAME(a_bit_range, clock, reset,
      phase_ff == PH_START || phase_ff == PH_BIT, bit_ff < 4'd8)

endmodule

>>> rtl/ir_pr_rsp_reg.sv
// Result register of the IR packet receiver, holding one item for the consumer.
// Depends on ir_pr_pkg for result_type.
module ir_pr_rsp_reg
   import ir_pr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp_data,
   output logic       space
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The slot can take a new item when empty or when it empties now.
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
